[src/fcss_pkg.sv]
// Package for the fan curve speed selector: sizes, field widths, codes and
// the table entry type. No dependencies.
package fcss_pkg;

   localparam int NUM_SOURCES        = 4;
   localparam int ENTRIES_PER_SOURCE = 16;
   localparam int TABLE_DEPTH        = NUM_SOURCES * ENTRIES_PER_SOURCE;

   localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int SIDX_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
   localparam int EIDX_W = (ENTRIES_PER_SOURCE > 1) ? $clog2(ENTRIES_PER_SOURCE) : 1;

   localparam int KIND_W   = 2;
   localparam int SRC_W    = 4;
   localparam int TEMP_W   = 16;
   localparam int ENT_W    = 4;
   localparam int DEG_W    = 8;
   localparam int SPEED_W  = 8;
   localparam int MODE_W   = 2;
   localparam int RPM_W    = 16;
   localparam int PWM_W    = 8;
   localparam int DBG_W    = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // (t / 10) for 16-bit t is (t * 52429) >> 19
   localparam int DIV10_MUL_W = 17;
   localparam logic [DIV10_MUL_W-1:0] DIV10_MUL = 17'd52429;
   localparam int DIV10_SHIFT = 19;
   localparam int PROD_W      = TEMP_W + DIV10_MUL_W;

   localparam int SCALE_W = 7;
   localparam logic [SCALE_W-1:0] RPM_SCALE = 7'd100;

   localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_TICK   = 2'd2;

   localparam logic [MODE_W-1:0] MODE_OFF = 2'd0;
   localparam logic [MODE_W-1:0] MODE_RPM = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PWM = 2'd2;

   localparam int DBG_ON_BIT  = 0;
   localparam int DBG_FAN_BIT = 1;
   localparam int DBG_PWM_BIT = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_ALLOW_ON    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEBUG_MODE  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEBUG_RPM   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DEBUG_PWM   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FAN_ENABLED = 3'd4;

   typedef struct packed {
      logic [DEG_W-1:0]   low;
      logic [DEG_W-1:0]   high;
      logic [SPEED_W-1:0] speed;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef logic [NUM_SOURCES-1:0][TEMP_W-1:0] temp_bank_type;

   typedef struct packed {
      logic start;
   } scan_ctl_type;

   typedef struct packed {
      logic               busy;
      logic               done;
      logic [SPEED_W-1:0] best;
   } scan_sts_type;

endpackage

[src/fcss_if.sv]
// Request and response channel interfaces of the fan curve speed selector.
// Depends on fcss_pkg.
interface fcss_req_if
   import fcss_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [SRC_W-1:0]    source_id;
   logic [TEMP_W-1:0]   temperature;
   logic [ENT_W-1:0]    entry_index;
   logic [DEG_W-1:0]    bound_low;
   logic [DEG_W-1:0]    bound_high;
   logic [SPEED_W-1:0]  speed_code;
   logic                entry_valid;
   logic                in_s0;

   modport source (output valid, kind, source_id, temperature, entry_index, bound_low,
                   bound_high, speed_code, entry_valid, in_s0, input ready);
   modport sink   (input valid, kind, source_id, temperature, entry_index, bound_low,
                   bound_high, speed_code, entry_valid, in_s0, output ready);
endinterface

interface fcss_rsp_if
   import fcss_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [MODE_W-1:0]  drive_mode;
   logic [RPM_W-1:0]   rpm_target;
   logic [PWM_W-1:0]   pwm_duty;
   logic               bad_source;

   modport source (output valid, drive_mode, rpm_target, pwm_duty, bad_source,
                   input ready);
   modport sink   (input valid, drive_mode, rpm_target, pwm_duty, bad_source,
                   output ready);
endinterface

[src/fan_curve_speed_selector_core.sv]
// Top level of the fan curve speed selector: control registers, source
// temperatures, table storage and result register.
// Depends on fcss_pkg, fcss_if, fcss_ram and fcss_scan.
//
// Usage:
//   req carries one transaction per event: a temperature sample (stored, then
//   evaluated), a table entry write, or an evaluate tick. rsp returns one result
//   per sample or tick; table writes and unknown kinds return nothing.
//   csr_we/csr_index/csr_wdata write the control registers; write them only
//   while the block is idle.
//   A table write or unknown kind leaves the block idle. An evaluation that needs
//   the curve lookup walks every table entry through one comparator, one entry per
//   cycle; its result then passes through the done state into the output
//   register, which raises rsp.valid. An evaluation settled by debug mode,
//   permission, power state or fan enable goes from the accept straight to the
//   done state. req.ready is high only between transactions, so the next one is
//   accepted once the result has left the done state.
//   A result is held in an output register; the next transaction is accepted
//   while it waits. A further result waits until rsp.ready takes the previous one.
//   Reset clears control registers other than fan enable, which it sets, and
//   clears temperatures and all entry valid bits; no clearing pass is needed.
module fan_curve_speed_selector_core
   import fcss_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   fcss_req_if.sink              req,
   fcss_rsp_if.source            rsp,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic                   allow_on_ff;
   logic [DBG_W-1:0]       debug_mode_ff;
   logic [RPM_W-1:0]       debug_rpm_ff;
   logic [PWM_W-1:0]       debug_pwm_ff;
   logic                   fan_enabled_ff;
   temp_bank_type          temps_ff;
   logic [TABLE_DEPTH-1:0] live_ff;
   logic                   s0_ff, s0_in;
   logic                   bad_ff, bad_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [MODE_W-1:0]      mode_ff, mode_in;
   logic [RPM_W-1:0]       rpm_ff, rpm_in;
   logic [PWM_W-1:0]       pwm_ff, pwm_in;
   logic                   bad_out_ff, bad_out_in;

   logic                   accept;
   logic                   is_eval;
   logic                   src_ok;
   logic                   ent_ok;
   logic                   table_we;
   logic [ADDR_W-1:0]      waddr;
   logic                   need_scan;
   logic                   load;
   logic [RPM_W-1:0]       rpm_pick;
   logic [SPEED_W+SCALE_W-1:0] lookup_rpm;
   scan_ctl_type           scan_ctl;
   scan_sts_type           scan_sts;
   logic [ADDR_W-1:0]      raddr;
   entry_type              rdata;
   entry_type              wentry;

   assign req.ready = (state_ff == ST_IDLE);
   assign accept    = req.valid && req.ready;
   assign is_eval   = (req.kind == KIND_SAMPLE) || (req.kind == KIND_TICK);
   assign src_ok    = {1'b0, req.source_id} < (SRC_W + 1)'(NUM_SOURCES);
   assign ent_ok    = {1'b0, req.entry_index} < (ENT_W + 1)'(ENTRIES_PER_SOURCE);
   assign table_we  = accept && (req.kind == KIND_WRITE) && src_ok && ent_ok;
   assign waddr     = ADDR_W'(ADDR_W'(req.source_id) * ADDR_W'(ENTRIES_PER_SOURCE)) +
                      ADDR_W'(req.entry_index);
   assign wentry    = '{low: req.bound_low, high: req.bound_high, speed: req.speed_code};
   assign need_scan = !debug_mode_ff[DBG_ON_BIT] && allow_on_ff && req.in_s0 &&
                      fan_enabled_ff;
   assign scan_ctl.start = accept && is_eval && need_scan;
   assign load      = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp.ready);

   fcss_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(TABLE_DEPTH)
   ) u_table (
      .clock (clock),
      .we    (table_we),
      .waddr (waddr),
      .wdata (wentry),
      .raddr (raddr),
      .rdata (rdata)
   );

   fcss_scan u_scan (
      .clock (clock),
      .reset (reset),
      .ctl   (scan_ctl),
      .temps (temps_ff),
      .live  (live_ff),
      .raddr (raddr),
      .rdata (rdata),
      .sts   (scan_sts)
   );

   always_comb begin
      state_in = state_ff;
      s0_in    = s0_ff;
      bad_in   = bad_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && is_eval) begin
               s0_in    = req.in_s0;
               bad_in   = (req.kind == KIND_SAMPLE) && !src_ok;
               state_in = need_scan ? ST_SCAN : ST_DONE;
            end
         end
         ST_SCAN: begin
            if (scan_sts.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign lookup_rpm = scan_sts.best * (SPEED_W + SCALE_W)'(RPM_SCALE);

   always_comb begin
      pwm_in   = '0;
      rpm_pick = '0;
      if (debug_mode_ff[DBG_ON_BIT]) begin
         if (debug_mode_ff[DBG_FAN_BIT]) begin
            if (debug_mode_ff[DBG_PWM_BIT]) begin
               pwm_in = debug_pwm_ff;
            end else begin
               rpm_pick = debug_rpm_ff;
            end
         end
      end else if (allow_on_ff && s0_ff && fan_enabled_ff) begin
         rpm_pick = RPM_W'(lookup_rpm);
      end
      if (debug_mode_ff[DBG_ON_BIT] && debug_mode_ff[DBG_FAN_BIT] &&
          debug_mode_ff[DBG_PWM_BIT]) begin
         mode_in = MODE_PWM;
         rpm_in  = '0;
      end else if (rpm_pick != '0) begin
         mode_in = MODE_RPM;
         rpm_in  = rpm_pick;
      end else begin
         mode_in = MODE_OFF;
         rpm_in  = '0;
      end
      bad_out_in   = bad_ff;
      rsp_valid_in = load || (rsp_valid_ff && !rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         allow_on_ff    <= 1'b0;
         debug_mode_ff  <= '0;
         debug_rpm_ff   <= '0;
         debug_pwm_ff   <= '0;
         fan_enabled_ff <= 1'b1;
         temps_ff       <= '0;
         live_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_ALLOW_ON:    allow_on_ff    <= csr_wdata[0];
               CSR_DEBUG_MODE:  debug_mode_ff  <= csr_wdata[DBG_W-1:0];
               CSR_DEBUG_RPM:   debug_rpm_ff   <= csr_wdata[RPM_W-1:0];
               CSR_DEBUG_PWM:   debug_pwm_ff   <= csr_wdata[PWM_W-1:0];
               CSR_FAN_ENABLED: fan_enabled_ff <= csr_wdata[0];
               default: ;
            endcase
         end
         if (accept && (req.kind == KIND_SAMPLE) && src_ok) begin
            temps_ff[req.source_id[SIDX_W-1:0]] <= req.temperature;
         end
         if (table_we) begin
            live_ff[waddr] <= req.entry_valid;
         end
      end
      s0_ff  <= s0_in;
      bad_ff <= bad_in;
      if (load) begin
         mode_ff    <= mode_in;
         rpm_ff     <= rpm_in;
         pwm_ff     <= pwm_in;
         bad_out_ff <= bad_out_in;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.drive_mode = mode_ff;
   assign rsp.rpm_target = rpm_ff;
   assign rsp.pwm_duty   = pwm_ff;
   assign rsp.bad_source = bad_out_ff;

   a_scan_done_in_scan: assert property (@(posedge clock) disable iff (reset)
      scan_sts.done |-> (state_ff == ST_SCAN))
      else $error("scan finished outside of scan state");

   a_write_no_wait: assert property (@(posedge clock) disable iff (reset)
      (accept && !is_eval) |=> (state_ff == ST_IDLE) && !scan_sts.busy)
      else $error("table write or unknown kind left the block busy");

   a_off_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && (rsp.drive_mode == MODE_OFF)) |-> (rsp.rpm_target == '0) &&
      (rsp.pwm_duty == '0))
      else $error("off result carries a nonzero rpm or pwm");

   a_scan_only_when_asked: assert property (@(posedge clock) disable iff (reset)
      $rose(scan_sts.busy) |-> $past(scan_ctl.start))
      else $error("table walk started without a transaction");
endmodule

[src/fcss_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fcss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                             clock,
   input  logic                             we,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
   input  logic [WIDTH-1:0]                 wdata,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
   output logic [WIDTH-1:0]                 rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

[src/fcss_scan.sv]
// Table walk for the fan curve speed selector: one read and one range compare
// per cycle, keeping the highest matching speed code. Depends on fcss_pkg.
module fcss_scan
   import fcss_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  scan_ctl_type          ctl,
   input  temp_bank_type         temps,
   input  logic [TABLE_DEPTH-1:0] live,
   output logic [ADDR_W-1:0]     raddr,
   input  entry_type             rdata,
   output scan_sts_type          sts
);
   logic                busy_ff, busy_in;
   logic                issuing_ff, issuing_in;
   logic                stage_valid_ff, stage_valid_in;
   logic                stage_live_ff, stage_live_in;
   logic [SIDX_W-1:0]   src_ff, src_in;
   logic [EIDX_W-1:0]   ent_ff, ent_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [SPEED_W-1:0]  best_ff, best_in;
   logic [DEG_W-1:0]    deg;
   logic                hit;
   logic                done;

   assign deg  = prod_ff[DIV10_SHIFT +: DEG_W];
   assign hit  = stage_valid_ff && stage_live_ff && (deg > rdata.low) &&
                 (deg <= rdata.high) && (rdata.speed > best_ff);
   assign done = busy_ff && !issuing_ff && !stage_valid_ff;
   assign raddr = addr_ff;

   always_comb begin
      busy_in        = busy_ff;
      issuing_in     = issuing_ff;
      src_in         = src_ff;
      ent_in         = ent_ff;
      addr_in        = addr_ff;
      best_in        = hit ? rdata.speed : best_ff;
      stage_valid_in = issuing_ff;
      stage_live_in  = live[addr_ff];
      prod_in        = PROD_W'(temps[src_ff]) * PROD_W'(DIV10_MUL);
      if (ctl.start) begin
         busy_in    = 1'b1;
         issuing_in = 1'b1;
         src_in     = '0;
         ent_in     = '0;
         addr_in    = '0;
         best_in    = '0;
      end else if (issuing_ff) begin
         addr_in = addr_ff + ADDR_W'(1);
         if (ent_ff == EIDX_W'(ENTRIES_PER_SOURCE - 1)) begin
            ent_in = '0;
            if (src_ff == SIDX_W'(NUM_SOURCES - 1)) begin
               issuing_in = 1'b0;
            end else begin
               src_in = src_ff + SIDX_W'(1);
            end
         end else begin
            ent_in = ent_ff + EIDX_W'(1);
         end
      end else if (done) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff        <= 1'b0;
         issuing_ff     <= 1'b0;
         stage_valid_ff <= 1'b0;
      end else begin
         busy_ff        <= busy_in;
         issuing_ff     <= issuing_in;
         stage_valid_ff <= stage_valid_in;
      end
      stage_live_ff <= stage_live_in;
      src_ff        <= src_in;
      ent_ff        <= ent_in;
      addr_ff       <= addr_in;
      prod_ff       <= prod_in;
      best_ff       <= best_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done;
   assign sts.best = best_ff;
endmodule

[sim/fan_curve_speed_selector_core_tb.sv]
// Testbench for fan_curve_speed_selector_core: directed and random transactions
// checked against an in-bench fan command predictor. Depends on fcss_pkg, fcss_if and the core.
module fan_curve_speed_selector_core_tb;
   import fcss_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;
   localparam int DRAIN_CYCLES   = 100;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TRAFFIC_PHASES = 14;
   localparam int PHASE_ITEMS    = 110;
   localparam int SHOWN_LIMIT    = 10;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [SRC_W-1:0]   source;
      logic [TEMP_W-1:0]  temperature;
      logic [ENT_W-1:0]   entry_index;
      logic [DEG_W-1:0]   bound_low;
      logic [DEG_W-1:0]   bound_high;
      logic [SPEED_W-1:0] speed_code;
      logic               entry_valid;
      logic               in_s0;
   } fan_event_t;

   typedef struct packed {
      logic [MODE_W-1:0] drive_mode;
      logic [RPM_W-1:0]  rpm_target;
      logic [PWM_W-1:0]  pwm_duty;
      logic              bad_source;
   } fan_cmd_t;

   logic clock = 1'b0;
   logic reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   fcss_req_if req_bus();
   fcss_rsp_if rsp_bus();

   fan_curve_speed_selector_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .rsp       (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   logic               cfg_allow_on;
   logic [DBG_W-1:0]   cfg_debug_mode;
   logic [RPM_W-1:0]   cfg_debug_rpm;
   logic [PWM_W-1:0]   cfg_debug_pwm;
   logic               cfg_fan_enabled;

   logic [TEMP_W-1:0]  temp_bank   [NUM_SOURCES];
   logic [DEG_W-1:0]   curve_low   [TABLE_DEPTH];
   logic [DEG_W-1:0]   curve_high  [TABLE_DEPTH];
   logic [SPEED_W-1:0] curve_speed [TABLE_DEPTH];
   logic               curve_live  [TABLE_DEPTH];

   fan_cmd_t fan_cmd_q[$];
   int fail_count = 0;
   int shown_count = 0;
   int quiet_cycles = 0;
   int stall_left = 0;
   int stall_pct = 0;
   int gap_pct = 0;

   function automatic int curve_rpm();
      int best;
      int deg;
      int k;
      best = 0;
      for (int s = 0; s < NUM_SOURCES; s++) begin
         deg = (int'(temp_bank[s]) / 10) % 256;
         for (int e = 0; e < ENTRIES_PER_SOURCE; e++) begin
            k = s * ENTRIES_PER_SOURCE + e;
            if (curve_live[k] && deg > int'(curve_low[k]) && deg <= int'(curve_high[k]) &&
                int'(curve_speed[k]) > best)
               best = int'(curve_speed[k]);
         end
      end
      return best * 100;
   endfunction

   function automatic fan_cmd_t evaluate_fan_cmd(logic s0);
      fan_cmd_t cmd;
      int rpm;
      cmd = '0;
      cmd.drive_mode = MODE_OFF;
      rpm = 0;
      if (cfg_debug_mode[DBG_ON_BIT]) begin
         if (cfg_debug_mode[DBG_FAN_BIT] && cfg_debug_mode[DBG_PWM_BIT]) begin
            cmd.drive_mode = MODE_PWM;
            cmd.pwm_duty = cfg_debug_pwm;
            return cmd;
         end else if (cfg_debug_mode[DBG_FAN_BIT]) begin
            rpm = int'(cfg_debug_rpm);
         end
      end else if (cfg_allow_on && s0 && cfg_fan_enabled) begin
         rpm = curve_rpm();
      end
      if (rpm != 0) begin
         cmd.drive_mode = MODE_RPM;
         cmd.rpm_target = rpm[RPM_W-1:0];
      end
      return cmd;
   endfunction

   function automatic void predict_fan_cmd(fan_event_t ev);
      fan_cmd_t cmd;
      int k;
      case (ev.kind)
         KIND_SAMPLE: begin
            if (int'(ev.source) < NUM_SOURCES)
               temp_bank[ev.source[SIDX_W-1:0]] = ev.temperature;
            cmd = evaluate_fan_cmd(ev.in_s0);
            cmd.bad_source = (int'(ev.source) >= NUM_SOURCES);
            fan_cmd_q.push_back(cmd);
         end
         KIND_WRITE: begin
            if (int'(ev.source) < NUM_SOURCES && int'(ev.entry_index) < ENTRIES_PER_SOURCE) begin
               k = int'(ev.source) * ENTRIES_PER_SOURCE + int'(ev.entry_index);
               curve_low[k]   = ev.bound_low;
               curve_high[k]  = ev.bound_high;
               curve_speed[k] = ev.speed_code;
               curve_live[k]  = ev.entry_valid;
            end
         end
         KIND_TICK: begin
            cmd = evaluate_fan_cmd(ev.in_s0);
            cmd.bad_source = 1'b0;
            fan_cmd_q.push_back(cmd);
         end
         default: begin
         end
      endcase
   endfunction

   function automatic fan_event_t random_event();
      logic [63:0] r;
      r = {$urandom(), $urandom()};
      return r[$bits(fan_event_t)-1:0];
   endfunction

   function automatic fan_event_t sample_event(int src, int temp, logic s0);
      fan_event_t ev;
      ev = random_event();
      ev.kind = KIND_SAMPLE;
      ev.source = src[SRC_W-1:0];
      ev.temperature = temp[TEMP_W-1:0];
      ev.in_s0 = s0;
      return ev;
   endfunction

   function automatic fan_event_t write_event(int src, int idx, int lo, int hi, int spd,
                                              logic live);
      fan_event_t ev;
      ev = random_event();
      ev.kind = KIND_WRITE;
      ev.source = src[SRC_W-1:0];
      ev.entry_index = idx[ENT_W-1:0];
      ev.bound_low = lo[DEG_W-1:0];
      ev.bound_high = hi[DEG_W-1:0];
      ev.speed_code = spd[SPEED_W-1:0];
      ev.entry_valid = live;
      return ev;
   endfunction

   function automatic fan_event_t tick_event(logic s0);
      fan_event_t ev;
      ev = random_event();
      ev.kind = KIND_TICK;
      ev.in_s0 = s0;
      return ev;
   endfunction

   function automatic fan_event_t traffic_event();
      int pick;
      int k;
      int deg;
      int lo;
      logic s0;
      pick = $urandom_range(0, 99);
      s0 = ($urandom_range(0, 9) != 0);
      if (pick < 15) begin
         lo = $urandom_range(0, 250);
         if ($urandom_range(0, 19) == 0)
            return write_event($urandom_range(0, NUM_SOURCES - 1), $urandom_range(0, 15),
                               $urandom_range(0, 255), $urandom_range(0, 255),
                               $urandom_range(0, 255), $urandom_range(0, 1) != 0);
         return write_event($urandom_range(0, NUM_SOURCES - 1), $urandom_range(0, 15), lo,
                            (lo + $urandom_range(0, 40) > 255) ? 255 : lo + $urandom_range(0, 40),
                            $urandom_range(0, 255), $urandom_range(0, 9) != 0);
      end
      if (pick < 65) begin
         if ($urandom_range(0, 4) == 0)
            return sample_event($urandom_range(0, NUM_SOURCES - 1), $urandom_range(0, 65535), s0);
         if ($urandom_range(0, 19) == 0)
            return sample_event($urandom_range(NUM_SOURCES, 15), $urandom_range(0, 65535), s0);
         k = $urandom_range(0, TABLE_DEPTH - 1);
         if ($urandom_range(0, 1) == 0)
            deg = (int'(curve_low[k]) + $urandom_range(0, 2)) % 256;
         else
            deg = (int'(curve_high[k]) + $urandom_range(0, 1)) % 256;
         return sample_event(k / ENTRIES_PER_SOURCE,
                             deg * 10 + $urandom_range(0, 9) + 2560 * $urandom_range(0, 24), s0);
      end
      if (pick < 90)
         return tick_event(s0);
      return random_event();
   endfunction

   task automatic send_event(input fan_event_t ev);
      @(negedge clock);
      req_bus.valid       <= 1'b1;
      req_bus.kind        <= ev.kind;
      req_bus.source_id   <= ev.source;
      req_bus.temperature <= ev.temperature;
      req_bus.entry_index <= ev.entry_index;
      req_bus.bound_low   <= ev.bound_low;
      req_bus.bound_high  <= ev.bound_high;
      req_bus.speed_code  <= ev.speed_code;
      req_bus.entry_valid <= ev.entry_valid;
      req_bus.in_s0       <= ev.in_s0;
      forever begin
         @(posedge clock);
         if (req_bus.ready)
            break;
      end
      predict_fan_cmd(ev);
   endtask

   task automatic hold_off(input int cycles);
      @(negedge clock);
      req_bus.valid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (fan_cmd_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      @(negedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_ALLOW_ON:    cfg_allow_on    = value[0];
         CSR_DEBUG_MODE:  cfg_debug_mode  = value[DBG_W-1:0];
         CSR_DEBUG_RPM:   cfg_debug_rpm   = value[RPM_W-1:0];
         CSR_DEBUG_PWM:   cfg_debug_pwm   = value[PWM_W-1:0];
         CSR_FAN_ENABLED: cfg_fan_enabled = value[0];
         default: begin
         end
      endcase
   endtask

   task automatic apply_settings(input int allow, input int mode, input int rpm, input int pwm,
                                 input int fan);
      wait_idle();
      write_reg(CSR_ALLOW_ON, allow);
      write_reg(CSR_DEBUG_MODE, mode);
      write_reg(CSR_DEBUG_RPM, rpm);
      write_reg(CSR_DEBUG_PWM, pwm);
      write_reg(CSR_FAN_ENABLED, fan);
   endtask

   task automatic test_reset_state();
      send_event(tick_event(1'b1));
      send_event(sample_event(0, 300, 1'b1));
   endtask

   task automatic test_curve_lookup();
      apply_settings(1, 0, 0, 0, 1);
      send_event(write_event(0, 0, 20, 40, 30, 1'b1));
      send_event(write_event(1, 5, 35, 60, 55, 1'b1));
      send_event(write_event(2, 15, 0, 255, 255, 1'b0));
      send_event(write_event(3, 15, 254, 255, 200, 1'b1));
      send_event(write_event(9, 3, 0, 255, 255, 1'b1));
      send_event(sample_event(0, 209, 1'b1));
      send_event(sample_event(0, 210, 1'b1));
      send_event(sample_event(0, 409, 1'b1));
      send_event(sample_event(1, 600, 1'b1));
      send_event(sample_event(3, 2559, 1'b1));
      send_event(sample_event(3, 65535, 1'b1));
      send_event(sample_event(15, 0, 1'b1));
      send_event(write_event(2, 15, 0, 255, 255, 1'b0));
      send_event(sample_event(2, 1000, 1'b1));
      send_event(random_event() | {KIND_NONE, {($bits(fan_event_t) - KIND_W){1'b0}}});
      send_event(tick_event(1'b1));
   endtask

   task automatic test_power_gating();
      apply_settings(1, 0, 0, 0, 0);
      send_event(tick_event(1'b1));
      apply_settings(1, 0, 0, 0, 1);
      send_event(tick_event(1'b0));
      apply_settings(0, 0, 0, 0, 1);
      send_event(tick_event(1'b1));
   endtask

   task automatic test_debug_modes();
      for (int m = 0; m < 8; m++) begin
         apply_settings(m % 2, m, 65535, 255, 1);
         send_event(tick_event(1'b1));
      end
      apply_settings(1, 3, 0, 255, 1);
      send_event(tick_event(1'b1));
      apply_settings(1, 7, 65535, 0, 1);
      send_event(tick_event(1'b1));
   endtask

   task automatic test_random_traffic();
      int sent;
      fan_event_t ev;
      for (int p = 0; p < TRAFFIC_PHASES; p++) begin
         case (p)
            0: apply_settings(1, 0, 0, 0, 1);
            1: apply_settings(0, 0, 65535, 255, 1);
            2: apply_settings(1, 7, 65535, 255, 0);
            3: apply_settings(1, 3, 65535, 0, 1);
            4: apply_settings(1, 0, $urandom_range(0, 65535), $urandom_range(0, 255), 0);
            5: apply_settings(1, 3, 0, $urandom_range(0, 255), 1);
            default: begin
               if ($urandom_range(0, 4) != 0)
                  apply_settings(1, 0, $urandom_range(0, 65535), $urandom_range(0, 255), 1);
               else
                  apply_settings($urandom_range(0, 1), $urandom_range(0, 7),
                                 $urandom_range(0, 65535), $urandom_range(0, 255),
                                 $urandom_range(0, 1));
            end
         endcase
         if (p == TRAFFIC_PHASES - 1 || p % 4 == 3) begin
            gap_pct = 0;
            stall_pct = 0;
         end else begin
            gap_pct = $urandom_range(5, 30);
            stall_pct = $urandom_range(5, 30);
         end
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
               hold_off($urandom_range(1, 11));
            ev = traffic_event();
            send_event(ev);
            if (ev.kind != KIND_NONE)
               sent++;
         end
      end
   endtask

   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_bus.ready <= 1'b0;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
         stall_left <= $urandom_range(0, 10);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      fan_cmd_t got;
      fan_cmd_t want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.drive_mode = rsp_bus.drive_mode;
         got.rpm_target = rsp_bus.rpm_target;
         got.pwm_duty   = rsp_bus.pwm_duty;
         got.bad_source = rsp_bus.bad_source;
         if (fan_cmd_q.size() == 0) begin
            fail_count++;
            if (shown_count < SHOWN_LIMIT) begin
               shown_count++;
               $display("unexpected result: mode %0d rpm %0d pwm %0d bad %0d",
                        got.drive_mode, got.rpm_target, got.pwm_duty, got.bad_source);
            end
         end else begin
            want = fan_cmd_q.pop_front();
            if (got.drive_mode !== want.drive_mode || got.rpm_target !== want.rpm_target ||
                got.pwm_duty !== want.pwm_duty || got.bad_source !== want.bad_source) begin
               fail_count++;
               if (shown_count < SHOWN_LIMIT) begin
                  shown_count++;
                  $display("mismatch: expected mode %0d rpm %0d pwm %0d bad %0d",
                           want.drive_mode, want.rpm_target, want.pwm_duty, want.bad_source);
                  $display("          actual   mode %0d rpm %0d pwm %0d bad %0d",
                           got.drive_mode, got.rpm_target, got.pwm_duty, got.bad_source);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset               <= 1'b1;
      csr_we              <= 1'b0;
      csr_index           <= '0;
      csr_wdata           <= '0;
      req_bus.valid       <= 1'b0;
      req_bus.kind        <= '0;
      req_bus.source_id   <= '0;
      req_bus.temperature <= '0;
      req_bus.entry_index <= '0;
      req_bus.bound_low   <= '0;
      req_bus.bound_high  <= '0;
      req_bus.speed_code  <= '0;
      req_bus.entry_valid <= 1'b0;
      req_bus.in_s0       <= 1'b0;
      cfg_allow_on    = 1'b0;
      cfg_debug_mode  = '0;
      cfg_debug_rpm   = '0;
      cfg_debug_pwm   = '0;
      cfg_fan_enabled = 1'b1;
      for (int i = 0; i < NUM_SOURCES; i++)
         temp_bank[i] = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         curve_low[i]   = '0;
         curve_high[i]  = '0;
         curve_speed[i] = '0;
         curve_live[i]  = 1'b0;
      end
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      gap_pct = $urandom_range(5, 30);
      stall_pct = $urandom_range(5, 30);
      test_reset_state();
      test_curve_lookup();
      test_power_gating();
      test_debug_modes();
      test_random_traffic();
      wait_idle();
      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

[fan_curve_speed_selector_core.f]
src/fcss_pkg.sv
src/fcss_if.sv
src/fcss_ram.sv
src/fcss_scan.sv
src/fan_curve_speed_selector_core.sv
sim/fan_curve_speed_selector_core_tb.sv
